@@ design/wtas_pkg.sv @@
// Package for the wingsail tail angle search: constants, position tables, shared types.
`default_nettype none
package wtas_pkg;

  localparam int NUM_POSITIONS = 53;
  localparam int CENTER        = (NUM_POSITIONS - 1) / 2;
  localparam int J_MAX         = NUM_POSITIONS - 1 - CENTER;
  localparam int IDX_W         = $clog2(NUM_POSITIONS);

  localparam int DIR_W   = 14;
  localparam int ANGLE_W = 6;
  localparam int LIM_W   = 5;
  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(13);

  // one turn in 1/16 degree
  localparam int TURN    = 5760;
  localparam int QUARTER = 1440;
  localparam int THETA_W = 13;
  localparam int OFF_W   = 11;

  localparam longint LIFT_MAX_Q12 = 65392;
  localparam longint DRAG_MAX_Q12 = 14837;
  localparam longint CENTER_SQ    = longint'(CENTER) * CENTER;

  localparam longint LIFT_PEAK = (LIFT_MAX_Q12 * J_MAX + CENTER / 2) / CENTER;
  localparam longint DRAG_PEAK = (DRAG_MAX_Q12 * J_MAX * J_MAX + CENTER_SQ / 2) / CENTER_SQ;
  localparam int LIFT_W = $clog2(LIFT_PEAK + 1) + 1;
  localparam int DRAG_W = $clog2(DRAG_PEAK + 1) + 1;

  // Q14 sine / cosine, magnitude at most 25736
  localparam int SIN_W    = 16;
  localparam int PROD_L_W = LIFT_W + SIN_W;
  localparam int PROD_D_W = DRAG_W + SIN_W;
  localparam int F_W      = ((PROD_L_W > PROD_D_W) ? PROD_L_W : PROD_D_W) + 1;

  // signed command before clamping, wide enough for the limit too
  localparam int CMD_W = ((IDX_W > LIM_W) ? IDX_W : LIM_W) + 2;

  // t = round(r * 32768 / 1440) = floor((2048 r + 45) / 90), via reciprocal
  localparam int     MUL_W        = 23;
  localparam int     PROD_W       = 2 * MUL_W;
  localparam int     RECIP_SHIFT  = 29;
  localparam int     RECIP_DIV    = 90;
  localparam longint RECIP_K      = ((longint'(1) << RECIP_SHIFT) + RECIP_DIV - 1) / RECIP_DIV;
  localparam int     RECIP_BIAS   = 45;
  localparam int     Q15_SHIFT    = 15;
  localparam int     T_W          = 16;
  localparam logic [T_W-1:0] SIN_K1 = T_W'(25736);
  localparam logic [T_W-1:0] SIN_K3 = T_W'(10512);
  localparam logic [T_W-1:0] SIN_K5 = T_W'(1160);

  typedef logic [NUM_POSITIONS-1:0][LIFT_W-1:0] lift_rom_t;
  typedef logic [NUM_POSITIONS-1:0][DRAG_W-1:0] drag_rom_t;

  function automatic lift_rom_t lift_rom_init();
    lift_rom_t rom;
    longint    j;
    longint    v;
    rom = '0;
    for (int i = 0; i < NUM_POSITIONS; i++) begin
      j = (i < CENTER) ? longint'(CENTER - i) : longint'(i - CENTER);
      v = (LIFT_MAX_Q12 * j + CENTER / 2) / CENTER;
      rom[i] = (i < CENTER) ? LIFT_W'(v) : LIFT_W'(-v);
    end
    return rom;
  endfunction

  function automatic drag_rom_t drag_rom_init();
    drag_rom_t rom;
    longint    j;
    longint    v;
    rom = '0;
    for (int i = 0; i < NUM_POSITIONS; i++) begin
      j = (i < CENTER) ? longint'(CENTER - i) : longint'(i - CENTER);
      v = (DRAG_MAX_Q12 * j * j + CENTER_SQ / 2) / CENTER_SQ;
      rom[i] = DRAG_W'(-v);
    end
    return rom;
  endfunction

  localparam lift_rom_t LIFT_ROM = lift_rom_init();
  localparam drag_rom_t DRAG_ROM = drag_rom_init();

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP,
    ST_TRIG,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } wtas_state_t;

  typedef enum logic [2:0] {
    TS_RECIP,
    TS_SQR,
    TS_INNER,
    TS_MID,
    TS_OUT
  } trig_step_t;

  typedef struct packed {
    logic             capture;
    logic             wrap;
    logic             trig_en;
    trig_step_t       trig_step;
    logic             trig_cos;
    logic             scan_en;
    logic [IDX_W-1:0] scan_idx;
    logic             load_out;
  } wtas_cmd_t;

  typedef struct packed {
    logic wind_ok;
  } wtas_status_t;

endpackage
`default_nettype wire

@@ design/wingsail_tail_angle_search.sv @@
// Top level of the wingsail tail angle search: controller plus datapath.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | in_wind_dir, in_wind_valid
//  out_    | output    | out_valid/out_stall | out_tail_angle, out_command_valid
//  cfg_    | input     | cfg_wr_en           | cfg_wr_data (max_command_angle)
//
// A known wind goes from accept to result through wrap, sine and cosine on the one
// shared multiplier, a scan of all NUM_POSITIONS positions, drain and load.
// An unknown wind goes from wrap straight to the load. One transaction is in
// work at a time; the input reopens the cycle after the load, not before.
// The result sits in an output register; the next input is taken while it waits.
// Synchronous active-low reset; the clamp limit resets to 13.
`default_nettype none
module wingsail_tail_angle_search
  import wtas_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [DIR_W-1:0]   in_wind_dir,
  input  wire logic                      in_wind_valid,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [ANGLE_W-1:0]      out_tail_angle,
  output logic                           out_command_valid,
  input  wire logic                      cfg_wr_en,
  input  wire logic [LIM_W-1:0]          cfg_wr_data
);

  wtas_cmd_t    cmd;
  wtas_status_t status;

  wtas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  wtas_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_wind_dir       (in_wind_dir),
    .in_wind_valid     (in_wind_valid),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_tail_angle    (out_tail_angle),
    .out_command_valid (out_command_valid)
  );

endmodule
`default_nettype wire

@@ design/wtas_ctrl.sv @@
// Controller state machine: sequences wrap, sine/cosine steps, position scan, drain and result.
`default_nettype none
module wtas_ctrl
  import wtas_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  wire logic         out_stall,
  input  wire wtas_status_t status,
  output wtas_cmd_t         cmd
);

  wtas_state_t      state_r, state_nxt;
  trig_step_t       step_r, step_nxt;
  logic             cos_r, cos_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_POSITIONS - 1);

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cos_nxt   = cos_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_WRAP;
        end
      end
      ST_WRAP: begin
        if (status.wind_ok) begin
          state_nxt = ST_TRIG;
          step_nxt  = TS_RECIP;
          cos_nxt   = 1'b0;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_TRIG: begin
        case (step_r)
          TS_RECIP: step_nxt = TS_SQR;
          TS_SQR:   step_nxt = TS_INNER;
          TS_INNER: step_nxt = TS_MID;
          TS_MID:   step_nxt = TS_OUT;
          default: begin
            step_nxt = TS_RECIP;
            if (cos_r) begin
              state_nxt = ST_SCAN;
              idx_nxt   = '0;
            end else begin
              cos_nxt = 1'b1;
            end
          end
        endcase
      end
      ST_SCAN: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IDX_LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.trig_step = step_r;
    cmd.trig_cos  = cos_r;
    cmd.scan_idx  = idx_r;
    in_stall      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_WRAP:   cmd.wrap     = 1'b1;
      ST_TRIG:   cmd.trig_en  = 1'b1;
      ST_SCAN:   cmd.scan_en  = 1'b1;
      ST_RESULT: cmd.load_out = out_free;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= TS_RECIP;
      cos_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cos_r       <= cos_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/wtas_dp.sv @@
// Datapath: angle wrap, shared sine multiplier, force scan with best tracking, clamp, output.
`default_nettype none
module wtas_dp
  import wtas_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire wtas_cmd_t                 cmd,
  output wtas_status_t                   status,
  input  wire logic signed [DIR_W-1:0]   in_wind_dir,
  input  wire logic                      in_wind_valid,
  input  wire logic                      cfg_wr_en,
  input  wire logic [LIM_W-1:0]          cfg_wr_data,
  output logic signed [ANGLE_W-1:0]      out_tail_angle,
  output logic                           out_command_valid
);

  localparam int NEG_W = DIR_W + 1;
  localparam logic signed [NEG_W-1:0] TURN_S     = NEG_W'(TURN);
  localparam logic signed [NEG_W-1:0] TURN2_S    = NEG_W'(2 * TURN);
  localparam logic signed [NEG_W-1:0] NEG_TURN_S = -NEG_W'(TURN);
  localparam logic [THETA_W-1:0] Q1_T = THETA_W'(QUARTER);
  localparam logic [THETA_W-1:0] Q2_T = THETA_W'(2 * QUARTER);
  localparam logic [THETA_W-1:0] Q3_T = THETA_W'(3 * QUARTER);
  localparam logic [OFF_W-1:0]   QUARTER_O = OFF_W'(QUARTER);
  localparam logic [MUL_W-1:0]   RECIP_K_M = MUL_W'(RECIP_K);
  localparam logic [MUL_W-1:0]   BIAS_M    = MUL_W'(RECIP_BIAS);
  localparam logic signed [CMD_W-1:0] CENTER_C = CMD_W'(CENTER);

  logic signed [DIR_W-1:0]   dir_r, dir_nxt;
  logic                      wv_r, wv_nxt;
  logic [1:0]                q_r, q_nxt;
  logic [OFF_W-1:0]          r_r, r_nxt;
  logic [T_W-1:0]            t_r, t_nxt;
  logic [T_W-1:0]            t2_r, t2_nxt;
  logic [T_W-1:0]            acc_r, acc_nxt;
  logic signed [SIN_W-1:0]   sin_r, sin_nxt;
  logic signed [SIN_W-1:0]   cos_r, cos_nxt;
  logic signed [PROD_D_W-1:0] p_drag_r, p_drag_nxt;
  logic signed [PROD_L_W-1:0] p_lift_r, p_lift_nxt;
  logic [IDX_W-1:0]          pidx_r, pidx_nxt;
  logic                      pvld_r, pvld_nxt;
  logic signed [F_W-1:0]     best_f_r, best_f_nxt;
  logic [IDX_W-1:0]          best_idx_r, best_idx_nxt;
  logic [LIM_W-1:0]          lim_r, lim_nxt;
  logic signed [ANGLE_W-1:0] out_tail_r, out_tail_nxt;
  logic                      out_cmd_r, out_cmd_nxt;

  logic signed [NEG_W-1:0]   neg_dir;
  logic signed [NEG_W-1:0]   wrapped;
  logic [THETA_W-1:0]        theta;
  logic [1:0]                quad;
  logic [OFF_W-1:0]          off;
  logic [MUL_W-1:0]          mul_a, mul_b;
  logic [PROD_W-1:0]         prod;
  logic [T_W-1:0]            prod_q15;
  logic signed [SIN_W-1:0]   trig_val;
  logic signed [DRAG_W-1:0]  drag_sel;
  logic signed [LIFT_W-1:0]  lift_sel;
  logic signed [F_W-1:0]     force_x;
  logic signed [CMD_W-1:0]   cmd_raw, lim_s, cmd_clamped;

  // direction negated and wrapped into one turn
  always_comb begin
    neg_dir = NEG_W'(0) - NEG_W'(dir_r);
    if (neg_dir < NEG_TURN_S) begin
      wrapped = neg_dir + TURN2_S;
    end else if (neg_dir < 0) begin
      wrapped = neg_dir + TURN_S;
    end else if (neg_dir >= TURN_S) begin
      wrapped = neg_dir - TURN_S;
    end else begin
      wrapped = neg_dir;
    end
    theta = wrapped[THETA_W-1:0];
  end

  // shared multiplier for the quarter-wave polynomial
  always_comb begin
    quad = q_r + {1'b0, cmd.trig_cos};
    off  = quad[0] ? (QUARTER_O - r_r) : r_r;
    case (cmd.trig_step)
      TS_RECIP: begin
        mul_a = MUL_W'({off, 11'd0}) + BIAS_M;
        mul_b = RECIP_K_M;
      end
      TS_SQR: begin
        mul_a = MUL_W'(t_r);
        mul_b = MUL_W'(t_r);
      end
      TS_INNER: begin
        mul_a = MUL_W'(SIN_K5);
        mul_b = MUL_W'(t2_r);
      end
      TS_MID: begin
        mul_a = MUL_W'(acc_r);
        mul_b = MUL_W'(t2_r);
      end
      TS_OUT: begin
        mul_a = MUL_W'(acc_r);
        mul_b = MUL_W'(t_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
    prod_q15 = prod[Q15_SHIFT+T_W-1:Q15_SHIFT];
    trig_val = quad[1] ? -$signed(prod_q15) : $signed(prod_q15);
  end

  always_comb begin
    drag_sel = $signed(DRAG_ROM[cmd.scan_idx]);
    lift_sel = $signed(LIFT_ROM[cmd.scan_idx]);
    force_x  = F_W'(p_drag_r) - F_W'(p_lift_r);
  end

  always_comb begin
    cmd_raw = CENTER_C - $signed(CMD_W'(best_idx_r));
    lim_s   = $signed(CMD_W'(lim_r));
    if (cmd_raw > lim_s) begin
      cmd_clamped = lim_s;
    end else if (cmd_raw < -lim_s) begin
      cmd_clamped = -lim_s;
    end else begin
      cmd_clamped = cmd_raw;
    end
  end

  always_comb begin
    dir_nxt      = dir_r;
    wv_nxt       = wv_r;
    q_nxt        = q_r;
    r_nxt        = r_r;
    t_nxt        = t_r;
    t2_nxt       = t2_r;
    acc_nxt      = acc_r;
    sin_nxt      = sin_r;
    cos_nxt      = cos_r;
    p_drag_nxt   = p_drag_r;
    p_lift_nxt   = p_lift_r;
    pidx_nxt     = cmd.scan_idx;
    pvld_nxt     = cmd.scan_en;
    best_f_nxt   = best_f_r;
    best_idx_nxt = best_idx_r;
    lim_nxt      = lim_r;
    out_tail_nxt = out_tail_r;
    out_cmd_nxt  = out_cmd_r;

    if (cfg_wr_en) begin
      lim_nxt = cfg_wr_data;
    end

    if (cmd.capture) begin
      dir_nxt = in_wind_dir;
      wv_nxt  = in_wind_valid;
    end

    if (cmd.wrap) begin
      if (theta >= Q3_T) begin
        q_nxt = 2'd3;
        r_nxt = OFF_W'(theta - Q3_T);
      end else if (theta >= Q2_T) begin
        q_nxt = 2'd2;
        r_nxt = OFF_W'(theta - Q2_T);
      end else if (theta >= Q1_T) begin
        q_nxt = 2'd1;
        r_nxt = OFF_W'(theta - Q1_T);
      end else begin
        q_nxt = 2'd0;
        r_nxt = OFF_W'(theta);
      end
    end

    if (cmd.trig_en) begin
      case (cmd.trig_step)
        TS_RECIP: t_nxt   = prod[RECIP_SHIFT+T_W-1:RECIP_SHIFT];
        TS_SQR:   t2_nxt  = prod_q15;
        TS_INNER: acc_nxt = SIN_K3 - prod_q15;
        TS_MID:   acc_nxt = SIN_K1 - prod_q15;
        default: begin
          if (cmd.trig_cos) begin
            cos_nxt = trig_val;
          end else begin
            sin_nxt = trig_val;
          end
        end
      endcase
    end

    if (cmd.scan_en) begin
      p_drag_nxt = drag_sel * cos_r;
      p_lift_nxt = lift_sel * sin_r;
    end

    // first maximum wins
    if (pvld_r && ((pidx_r == '0) || (force_x > best_f_r))) begin
      best_f_nxt   = force_x;
      best_idx_nxt = pidx_r;
    end

    if (cmd.load_out) begin
      out_cmd_nxt  = wv_r;
      out_tail_nxt = wv_r ? ANGLE_W'(cmd_clamped) : '0;
    end
  end

  always_ff @(posedge clk) begin
    dir_r      <= dir_nxt;
    wv_r       <= wv_nxt;
    q_r        <= q_nxt;
    r_r        <= r_nxt;
    t_r        <= t_nxt;
    t2_r       <= t2_nxt;
    acc_r      <= acc_nxt;
    sin_r      <= sin_nxt;
    cos_r      <= cos_nxt;
    p_drag_r   <= p_drag_nxt;
    p_lift_r   <= p_lift_nxt;
    pidx_r     <= pidx_nxt;
    best_f_r   <= best_f_nxt;
    best_idx_r <= best_idx_nxt;
    out_tail_r <= out_tail_nxt;
    out_cmd_r  <= out_cmd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
      lim_r  <= LIM_RESET;
    end else begin
      pvld_r <= pvld_nxt;
      lim_r  <= lim_nxt;
    end
  end

  assign status.wind_ok    = wv_r;
  assign out_tail_angle    = out_tail_r;
  assign out_command_valid = out_cmd_r;

endmodule
`default_nettype wire

@@ design/wtas_checker.sv @@
// Port-level checker for the tail angle search, bound to the top level.
`default_nettype none
module wtas_checker
  import wtas_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic signed [DIR_W-1:0] in_wind_dir,
  input wire logic                    in_wind_valid,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic signed [ANGLE_W-1:0] out_tail_angle,
  input wire logic                    out_command_valid,
  input wire logic                    cfg_wr_en,
  input wire logic [LIM_W-1:0]        cfg_wr_data
);

  localparam logic signed [ANGLE_W-1:0] HI_A = ANGLE_W'(CENTER);
  localparam logic signed [ANGLE_W-1:0] LO_A = -ANGLE_W'(J_MAX);

  a_no_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_command_valid |-> out_tail_angle == '0)
    else $error("no-command result carries a nonzero angle");

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while one is in work");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command_valid |-> out_tail_angle <= HI_A && out_tail_angle >= LO_A)
    else $error("tail angle outside the position range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_tail_angle) && $stable(out_command_valid))
    else $error("stalled result changed or dropped");

endmodule

bind wingsail_tail_angle_search wtas_checker u_wtas_checker (.*);
`default_nettype wire

@@ bench/wingsail_tail_angle_search_tb.sv @@
// Testbench for wingsail_tail_angle_search: a directed table, then random wind transactions.
`timescale 1ns / 100ps
module wingsail_tail_angle_search_tb;
  import wtas_pkg::*;

  localparam int POSITIONS         = 53;
  localparam int MID_POS           = (POSITIONS - 1) / 2;
  localparam int FULL_TURN         = 5760;
  localparam int QTR_TURN          = 1440;
  localparam int DIR_SPAN          = 5760;
  localparam int LIMIT_AFTER_RESET = 13;
  localparam int TAIL_LATENCY      = 80;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic                      cmd_valid;
  } tail_cmd_t;

  typedef enum logic {ROW_WIND, ROW_LIMIT} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [LIM_W-1:0]        limit;
    logic signed [DIR_W-1:0] dir;
    logic                    known;
    logic                    typed;
    tail_cmd_t               cmd;
  } stim_row_t;

  localparam int NUM_ROWS = 26;
  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    '{ROW_WIND,  5'd0,  14'sd0,     1'b1, 1'b1, '{6'sd0,   1'b1}},
    '{ROW_WIND,  5'd0,  14'sd0,     1'b0, 1'b1, '{6'sd0,   1'b0}},
    '{ROW_WIND,  5'd0,  14'sd2880,  1'b1, 1'b1, '{6'sd13,  1'b1}},
    '{ROW_WIND,  5'd0,  14'sd1440,  1'b1, 1'b1, '{6'sd13,  1'b1}},
    '{ROW_WIND,  5'd0,  -14'sd1440, 1'b1, 1'b1, '{-6'sd13, 1'b1}},
    '{ROW_WIND,  5'd0,  14'sd5760,  1'b1, 1'b1, '{6'sd0,   1'b1}},
    '{ROW_WIND,  5'd0,  -14'sd5760, 1'b1, 1'b1, '{6'sd0,   1'b1}},
    '{ROW_WIND,  5'd0,  -14'sd2880, 1'b1, 1'b1, '{6'sd13,  1'b1}},
    '{ROW_WIND,  5'd0,  14'sd5759,  1'b1, 1'b0, '{6'sd0,   1'b0}},
    '{ROW_WIND,  5'd0,  -14'sd5759, 1'b1, 1'b0, '{6'sd0,   1'b0}},
    '{ROW_WIND,  5'd0,  14'sd100,   1'b1, 1'b0, '{6'sd0,   1'b0}},
    '{ROW_WIND,  5'd0,  14'sd4000,  1'b0, 1'b1, '{6'sd0,   1'b0}},
    '{ROW_LIMIT, 5'd31, 14'sd0,     1'b0, 1'b0, '{6'sd0,   1'b0}},
    '{ROW_WIND,  5'd0,  14'sd2880,  1'b1, 1'b1, '{6'sd26,  1'b1}},
    '{ROW_WIND,  5'd0,  14'sd1440,  1'b1, 1'b1, '{6'sd26,  1'b1}},
    '{ROW_WIND,  5'd0,  -14'sd1440, 1'b1, 1'b1, '{-6'sd26, 1'b1}},
    '{ROW_WIND,  5'd0,  14'sd720,   1'b1, 1'b0, '{6'sd0,   1'b0}},
    '{ROW_LIMIT, 5'd0,  14'sd0,     1'b0, 1'b0, '{6'sd0,   1'b0}},
    '{ROW_WIND,  5'd0,  14'sd1440,  1'b1, 1'b1, '{6'sd0,   1'b1}},
    '{ROW_WIND,  5'd0,  -14'sd3000, 1'b1, 1'b1, '{6'sd0,   1'b1}},
    '{ROW_WIND,  5'd0,  -14'sd5760, 1'b0, 1'b1, '{6'sd0,   1'b0}},
    '{ROW_LIMIT, 5'd26, 14'sd0,     1'b0, 1'b0, '{6'sd0,   1'b0}},
    '{ROW_WIND,  5'd0,  14'sd2880,  1'b1, 1'b1, '{6'sd26,  1'b1}},
    '{ROW_WIND,  5'd0,  -14'sd1440, 1'b1, 1'b1, '{-6'sd26, 1'b1}},
    '{ROW_WIND,  5'd0,  14'sd3333,  1'b1, 1'b0, '{6'sd0,   1'b0}},
    '{ROW_WIND,  5'd0,  -14'sd1,    1'b1, 1'b0, '{6'sd0,   1'b0}}
  };

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [DIR_W-1:0]   in_wind_dir;
  logic                      in_wind_valid;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [ANGLE_W-1:0] out_tail_angle;
  logic                      out_command_valid;
  logic                      cfg_wr_en;
  logic [LIM_W-1:0]          cfg_wr_data;

  logic [LIM_W-1:0] angle_limit;
  int               send_gap_pct   = 0;
  int               recv_stall_pct = 0;
  int               mismatches     = 0;
  tail_cmd_t        pending_cmds[$];

  wingsail_tail_angle_search dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_wind_dir       (in_wind_dir),
    .in_wind_valid     (in_wind_valid),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tail_angle    (out_tail_angle),
    .out_command_valid (out_command_valid),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  // Q14 sine over one quarter turn, polynomial in Q15
  function automatic longint quarter_wave(int unsigned off);
    longint unsigned t, t2, inner, mid;
    if (off > QTR_TURN) off = QTR_TURN;
    t     = (longint'(off) * 32768 + QTR_TURN / 2) / QTR_TURN;
    t2    = (t * t) >> 15;
    inner = 64'd10512 - ((64'd1160 * t2) >> 15);
    mid   = 64'd25736 - ((inner * t2) >> 15);
    return longint'((mid * t) >> 15);
  endfunction

  function automatic longint wave_q14(int unsigned theta);
    int unsigned quad, off;
    quad = (theta / QTR_TURN) % 4;
    off  = theta % QTR_TURN;
    case (quad)
      0: return quarter_wave(off);
      1: return quarter_wave(QTR_TURN - off);
      2: return -quarter_wave(off);
      default: return -quarter_wave(QTR_TURN - off);
    endcase
  endfunction

  function automatic tail_cmd_t predict_tail(logic signed [DIR_W-1:0] dir, logic known,
                                             logic [LIM_W-1:0] lim);
    tail_cmd_t r;
    int        heading, best, cmd, span, lim_i;
    longint    sn, cs, lift, drag, force_x, best_force;
    r = '0;
    if (!known) return r;
    heading = (-int'(dir)) % FULL_TURN;
    if (heading < 0) heading += FULL_TURN;
    sn = wave_q14(heading);
    cs = wave_q14((heading + QTR_TURN) % FULL_TURN);
    best       = 0;
    best_force = 0;
    for (int i = 0; i < POSITIONS; i++) begin
      span = (i < MID_POS) ? MID_POS - i : i - MID_POS;
      lift = (longint'(65392) * span + MID_POS / 2) / MID_POS;
      if (i >= MID_POS) lift = -lift;
      drag = -((longint'(14837) * span * span + (MID_POS * MID_POS) / 2) /
               (MID_POS * MID_POS));
      force_x = drag * cs - lift * sn;
      if (i == 0 || force_x > best_force) begin
        best_force = force_x;
        best       = i;
      end
    end
    cmd   = MID_POS - best;
    lim_i = int'(lim);
    if (cmd > lim_i) cmd = lim_i;
    if (cmd < -lim_i) cmd = -lim_i;
    r.angle     = cmd[ANGLE_W-1:0];
    r.cmd_valid = 1'b1;
    return r;
  endfunction

  task automatic send_item(input logic signed [DIR_W-1:0] dir, input logic known,
                           input logic typed, input tail_cmd_t typed_cmd);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid      = 1'b0;
      in_wind_dir   = DIR_W'($urandom);
      in_wind_valid = 1'($urandom_range(1));
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_wind_dir   = dir;
    in_wind_valid = known;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_cmds.insert(pending_cmds.size(),
                        typed ? typed_cmd : predict_tail(dir, known, angle_limit));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIM_W-1:0] value);
    wait_idle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    angle_limit = value;
  endtask

  task automatic send_random_item();
    int   pick, dir_i;
    logic known;
    pick  = $urandom_range(99);
    known = (pick >= 8);
    // near quadrant boundaries
    if (pick >= 8 && pick < 35)
      dir_i = (int'($urandom_range(8)) - 4) * QTR_TURN + int'($urandom_range(8)) - 4;
    else
      dir_i = int'($urandom_range(2 * DIR_SPAN)) - DIR_SPAN;
    if (dir_i > DIR_SPAN) dir_i = DIR_SPAN;
    if (dir_i < -DIR_SPAN) dir_i = -DIR_SPAN;
    send_item(DIR_W'(dir_i), known, 1'b0, '0);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    tail_cmd_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: tail_angle %0d command_valid %0b",
                   out_tail_angle, out_command_valid);
      end else begin
        want = pending_cmds.pop_front();
        if (out_tail_angle !== want.angle || out_command_valid !== want.cmd_valid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tail cmd: expected angle %0d valid %0b, got angle %0d valid %0b",
                     want.angle, want.cmd_valid, out_tail_angle, out_command_valid);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("wingsail_tail_angle_search: mismatch");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_wind_dir   = '0;
    in_wind_valid = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    angle_limit   = LIM_W'(LIMIT_AFTER_RESET);
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    send_gap_pct   = 26;
    recv_stall_pct = 79;
    for (int k = 0; k < NUM_ROWS; k++) begin
      if (DIRECTED[k].kind == ROW_LIMIT) begin
        write_limit(DIRECTED[k].limit);
      end else begin
        send_item(DIRECTED[k].dir, DIRECTED[k].known, DIRECTED[k].typed, DIRECTED[k].cmd);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          send_gap_pct   = 26;
          recv_stall_pct = 79;
        end
        1: begin
          send_gap_pct   = 79;
          recv_stall_pct = 26;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        case (phase * 2 + seg)
          0: write_limit(LIM_W'(26));
          1: write_limit(LIM_W'(5));
          2: write_limit(LIM_W'(31));
          3: write_limit(LIM_W'($urandom_range(31)));
          4: write_limit(LIM_W'(1));
          default: write_limit(LIM_W'(20));
        endcase
        repeat (217) send_random_item();
      end
    end

    wait_idle();
    repeat (TAIL_LATENCY) @(posedge clk);
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("wingsail_tail_angle_search: match");
    end else begin
      $display("wingsail_tail_angle_search: mismatch");
    end
    $finish;
  end

endmodule
